### sv/vbss_pkg.sv
// ----------------------------------------------------------------------------
// Vehicle bus signal scaler package
// Shared widths, frame kinds, transfer records and scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package vbss_pkg;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int RPM_W    = 14;
    localparam int STEER_W  = 12;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RPM     = 3'd0,
        OP_SPEED   = 3'd1,
        OP_FUEL    = 3'd2,
        OP_COOLANT = 3'd3,
        OP_OUTSIDE = 3'd4,
        OP_GEAR    = 3'd5,
        OP_STEER   = 3'd6
    } opcode_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   byte_zero;
        logic [BYTE_W-1:0]   byte_one;
        logic [BYTE_W-1:0]   byte_two;
        logic [BYTE_W-1:0]   byte_three;
    } frame_t;

    typedef struct packed {
        logic [RPM_W-1:0]          engine_rpm;
        logic [BYTE_W-1:0]         road_speed;
        logic [BYTE_W-1:0]         fuel_percent;
        logic signed [BYTE_W-1:0]  coolant_celsius;
        logic signed [BYTE_W-1:0]  outside_celsius;
        logic [BYTE_W-1:0]         gear_mode;
        logic [BYTE_W-1:0]         gear_number;
        logic signed [STEER_W-1:0] steering_degrees;
    } values_t;

    // Reciprocal constants: floor(n / d) == (n * RECIP) >> SHIFT over the
    // operand range that each conversion can produce.
    localparam logic [11:0] FUEL_DIV7_RECIP  = 12'd2341;
    localparam int          FUEL_DIV7_SHIFT  = 14;
    localparam logic [12:0] FUEL_DIV49_RECIP = 13'd5350;
    localparam int          FUEL_DIV49_SHIFT = 18;
    localparam logic [13:0] COOL_DIV100_RECIP = 14'd10486;
    localparam int          COOL_DIV100_SHIFT = 20;
    localparam logic [15:0] STEER_DIV25_RECIP = 16'd41944;
    localparam int          STEER_DIV25_SHIFT = 20;

    localparam logic [13:0] FUEL_LOW_OFFSET = 14'd230;
    localparam logic [14:0] COOL_OFFSET     = 15'd4837;
    localparam logic [7:0]  COOL_MAX        = 8'd127;

endpackage

`default_nettype wire

### sv/vbss_frame_if.sv
// ----------------------------------------------------------------------------
// Frame channel
// Valid/ready channel that carries one bus frame payload and its kind.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbss_frame_if
    import vbss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   byte_zero;
    logic [BYTE_W-1:0]   byte_one;
    logic [BYTE_W-1:0]   byte_two;
    logic [BYTE_W-1:0]   byte_three;

    modport source (
        output valid, opcode, byte_zero, byte_one, byte_two, byte_three,
        input  ready
    );

    modport sink (
        input  valid, opcode, byte_zero, byte_one, byte_two, byte_three,
        output ready
    );
endinterface

`default_nettype wire

### sv/vbss_values_if.sv
// ----------------------------------------------------------------------------
// Vehicle values channel
// Valid/ready channel that carries the full set of held vehicle values.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbss_values_if
    import vbss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [RPM_W-1:0]          engine_rpm;
    logic [BYTE_W-1:0]         road_speed;
    logic [BYTE_W-1:0]         fuel_percent;
    logic signed [BYTE_W-1:0]  coolant_celsius;
    logic signed [BYTE_W-1:0]  outside_celsius;
    logic [BYTE_W-1:0]         gear_mode;
    logic [BYTE_W-1:0]         gear_number;
    logic signed [STEER_W-1:0] steering_degrees;

    modport source (
        output valid, engine_rpm, road_speed, fuel_percent, coolant_celsius,
               outside_celsius, gear_mode, gear_number, steering_degrees,
        input  ready
    );

    modport sink (
        input  valid, engine_rpm, road_speed, fuel_percent, coolant_celsius,
               outside_celsius, gear_mode, gear_number, steering_degrees,
        output ready
    );
endinterface

`default_nettype wire

### sv/vehicle_bus_signal_scaler_core.sv
// ----------------------------------------------------------------------------
// Vehicle bus signal scaler
// Converts bus frames into held vehicle values and emits the full set.
// ----------------------------------------------------------------------------
// The frame channel takes one frame per transfer: a kind code and four
// payload bytes. Each accepted frame updates the held values that its kind
// names and produces exactly one transfer on the values channel that carries
// all eight held values after that update. An unused kind code changes
// nothing but still produces a transfer.
// A frame is registered at the edge that accepts it, converted from the input
// register combinationally, and its values are offered from the output
// register. One frame can be accepted in every cycle while the receiver does
// not stall; the rate is set by the single conversion stage.
// When the receiver stalls, the output register holds its values and the
// input register holds one more frame; ready drops only once both are full.
// Reset empties both registers and clears every held value to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_bus_signal_scaler_core
    import vbss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    vbss_frame_if.sink   frame,
    vbss_values_if.source values
);

    logic    in_valid_reg;
    logic    in_valid_next;
    frame_t  in_frame_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    values_t held_reg;
    values_t held_next;
    values_t converted;
    logic    out_ready;
    logic    in_ready;
    logic    advance;

    assign out_ready = !out_valid_reg || values.ready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_ready;

    assign in_valid_next  = in_ready ? frame.valid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    assign held_next      = advance ? converted : held_reg;

    vbss_convert u_convert (
        .frame   (in_frame_reg),
        .held    (held_reg),
        .updated (converted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && in_ready)
        begin
            in_frame_reg.opcode     <= frame.opcode;
            in_frame_reg.byte_zero  <= frame.byte_zero;
            in_frame_reg.byte_one   <= frame.byte_one;
            in_frame_reg.byte_two   <= frame.byte_two;
            in_frame_reg.byte_three <= frame.byte_three;
        end
    end

    assign frame.ready             = in_ready;
    assign values.valid            = out_valid_reg;
    assign values.engine_rpm       = held_reg.engine_rpm;
    assign values.road_speed       = held_reg.road_speed;
    assign values.fuel_percent     = held_reg.fuel_percent;
    assign values.coolant_celsius  = held_reg.coolant_celsius;
    assign values.outside_celsius  = held_reg.outside_celsius;
    assign values.gear_mode        = held_reg.gear_mode;
    assign values.gear_number      = held_reg.gear_number;
    assign values.steering_degrees = held_reg.steering_degrees;

endmodule

`default_nettype wire

### sv/vbss_convert.sv
// ----------------------------------------------------------------------------
// Frame conversion
// Scales one frame payload and merges it into the held vehicle values.
// ----------------------------------------------------------------------------
`default_nettype none

module vbss_convert
    import vbss_pkg::*;
(
    input  frame_t  frame,
    input  values_t held,
    output values_t updated
);

    logic [15:0] rpm_raw;
    logic [18:0] rpm_prod;

    logic [15:0] spd_word;
    logic [15:0] spd_prod;
    logic [12:0] spd_scaled;
    logic [7:0]  spd_val;

    logic [10:0] fh_num;
    logic [24:0] fh_prod;
    logic [7:0]  fuel_hi;

    logic [13:0] fl_num;
    logic        fl_pos;
    logic [13:0] fl_diff;
    logic [26:0] fl_prod;
    logic [7:0]  fuel_lo;

    logic [14:0] cl_num;
    logic        cl_neg;
    logic [14:0] cl_mag;
    logic [27:0] cl_prod;
    logic [7:0]  cl_q;
    logic [7:0]  cool_val;

    logic [7:0]  out_val;

    logic [14:0] st_mag;
    logic [18:0] st_prod;
    logic [15:0] st_y;
    logic [31:0] st_div;
    logic [10:0] st_q;
    logic [11:0] steer_val;

    assign rpm_raw  = {frame.byte_three, frame.byte_two};
    assign rpm_prod = {3'b0, rpm_raw} * 19'd5;

    assign spd_word   = {frame.byte_two, frame.byte_one};
    assign spd_prod   = {4'b0, spd_word[15:4]} * 16'd9;
    assign spd_scaled = spd_prod[15:3];
    assign spd_val    = (|spd_scaled[12:8]) ? 8'hFF : spd_scaled[7:0];

    assign fh_num  = {4'b0, frame.byte_two[6:0]} * 11'd10;
    assign fh_prod = {14'b0, fh_num} * {13'b0, FUEL_DIV7_RECIP};
    assign fuel_hi = fh_prod[FUEL_DIV7_SHIFT +: 8];

    assign fl_num  = {7'b0, frame.byte_two[6:0]} * 14'd90;
    assign fl_pos  = fl_num > FUEL_LOW_OFFSET;
    assign fl_diff = fl_num - FUEL_LOW_OFFSET;
    assign fl_prod = {13'b0, fl_diff} * {14'b0, FUEL_DIV49_RECIP};
    assign fuel_lo = fl_pos ? fl_prod[FUEL_DIV49_SHIFT +: 8] : 8'd0;

    assign cl_num   = {7'b0, frame.byte_one} * 15'd75;
    assign cl_neg   = cl_num < COOL_OFFSET;
    assign cl_mag   = cl_neg ? (COOL_OFFSET - cl_num) : (cl_num - COOL_OFFSET);
    assign cl_prod  = {14'b0, cl_mag[13:0]} * {14'b0, COOL_DIV100_RECIP};
    assign cl_q     = cl_prod[COOL_DIV100_SHIFT +: 8];
    assign cool_val = cl_neg ? (8'd0 - cl_q) : ((cl_q > COOL_MAX) ? COOL_MAX : cl_q);

    // Sign-magnitude byte; negative zero falls out as zero.
    assign out_val = frame.byte_three[7] ? (8'd0 - {1'b0, frame.byte_three[6:0]})
                                         : frame.byte_three;

    // Divide by 200 as a shift by three followed by a divide by 25.
    assign st_mag    = {frame.byte_one[6:0], frame.byte_zero};
    assign st_prod   = {4'b0, st_mag} * 19'd9;
    assign st_y      = st_prod[18:3];
    assign st_div    = {16'b0, st_y} * {16'b0, STEER_DIV25_RECIP};
    assign st_q      = st_div[STEER_DIV25_SHIFT +: 11];
    assign steer_val = frame.byte_one[7] ? (12'd0 - {1'b0, st_q}) : {1'b0, st_q};

    always_comb
    begin
        updated = held;
        case (frame.opcode)
            OP_RPM:
            begin
                updated.engine_rpm = rpm_prod[18:5];
            end
            OP_SPEED:
            begin
                updated.road_speed = spd_val;
            end
            OP_FUEL:
            begin
                updated.fuel_percent = frame.byte_two[7] ? fuel_hi : fuel_lo;
            end
            OP_COOLANT:
            begin
                updated.coolant_celsius = cool_val;
            end
            OP_OUTSIDE:
            begin
                updated.outside_celsius = out_val;
            end
            OP_GEAR:
            begin
                updated.gear_mode   = frame.byte_two;
                updated.gear_number = frame.byte_one;
            end
            OP_STEER:
            begin
                updated.steering_degrees = steer_val;
            end
            default:
            begin
                updated = held;
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/tb_vehicle_bus_signal_scaler_core.sv
// ----------------------------------------------------------------------------
// Vehicle bus signal scaler testbench
// Sends directed and random bus frames through the frame channel with random
// gaps. A predictor keeps its own copy of the held vehicle values and queues
// the full value set that each accepted frame should produce. Every transfer
// on the values channel is checked field by field against the oldest queued
// set while the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vehicle_bus_signal_scaler_core
    import vbss_pkg::*;
();

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_FRAMES = 1250;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTED   = 50;

    typedef struct {
        frame_t      payload;
        int unsigned gap;
        bit          drain_first;
    } frame_job_t;

    logic clk;
    logic rst_n = 1'b0;

    vbss_frame_if  frame_ch ();
    vbss_values_if values_ch ();

    vehicle_bus_signal_scaler_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .values (values_ch)
    );

    frame_job_t  pending_frames[$];
    values_t     expected_values[$];
    values_t     vehicle_state = '0;
    int          error_count = 0;
    bit          source_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int unsigned gap_left;
    bit          gap_armed;
    int unsigned stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [BYTE_W-1:0] random_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic values_t scale_frame(input frame_t f);
        int b0, b1, b2, b3, raw, level;
        b0 = f.byte_zero;
        b1 = f.byte_one;
        b2 = f.byte_two;
        b3 = f.byte_three;
        case (f.opcode)
            OP_RPM:
            begin
                raw = b3 * 256 + b2;
                vehicle_state.engine_rpm = RPM_W'((raw * 5) >> 5);
            end
            OP_SPEED:
            begin
                raw = (b2 * 256 + b1) >> 4;
                level = (raw * 9) >> 3;
                vehicle_state.road_speed = BYTE_W'(level > 255 ? 255 : level);
            end
            OP_FUEL:
            begin
                if (b2 >= 128)
                    level = ((b2 - 128) * 10) / 7;
                else
                begin
                    level = 90 * b2 - int'(FUEL_LOW_OFFSET);
                    level = level < 0 ? 0 : level / 49;
                end
                vehicle_state.fuel_percent = BYTE_W'(level);
            end
            OP_COOLANT:
            begin
                level = (75 * b1 - int'(COOL_OFFSET)) / 100;
                if (level > int'(COOL_MAX))
                    level = int'(COOL_MAX);
                vehicle_state.coolant_celsius = BYTE_W'(level);
            end
            OP_OUTSIDE:
            begin
                if (b3 > 128)
                    level = -(b3 - 128);
                else if (b3 == 128)
                    level = 0;
                else
                    level = b3;
                vehicle_state.outside_celsius = BYTE_W'(level);
            end
            OP_GEAR:
            begin
                vehicle_state.gear_mode = f.byte_two;
                vehicle_state.gear_number = f.byte_one;
            end
            OP_STEER:
            begin
                raw = b1 * 256 + b0;
                level = ((raw & 'h7FFF) * 9) / 200;
                if (raw[15])
                    level = -level;
                vehicle_state.steering_degrees = STEER_W'(level);
            end
            default:
            begin
            end
        endcase
        return vehicle_state;
    endfunction

    task automatic add_frame(input logic [OPCODE_W-1:0] op, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input bit drain_first);
        frame_job_t job;
        if ($urandom_range(0, 39) == 0)
            source_calm = !source_calm;
        job.payload = {op, b0, b1, b2, b3};
        job.gap = source_calm ? 0 : $urandom_range(0, 10);
        job.drain_first = drain_first;
        pending_frames.push_back(job);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_frames
        frame_job_t job;
        logic       offer;
        if (!rst_n)
        begin
            frame_ch.valid <= 1'b0;
            frame_ch.opcode <= OP_RPM;
            frame_ch.byte_zero <= '0;
            frame_ch.byte_one <= '0;
            frame_ch.byte_two <= '0;
            frame_ch.byte_three <= '0;
            gap_left = 0;
            gap_armed = 1'b0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
                expected_values.push_back(scale_frame({frame_ch.opcode, frame_ch.byte_zero,
                                                       frame_ch.byte_one, frame_ch.byte_two,
                                                       frame_ch.byte_three}));
            offer = frame_ch.valid && !frame_ch.ready;
            if (!offer && pending_frames.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left = pending_frames[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else if (!(pending_frames[0].drain_first && expected_values.size() != 0))
                begin
                    job = pending_frames.pop_front();
                    frame_ch.opcode <= job.payload.opcode;
                    frame_ch.byte_zero <= job.payload.byte_zero;
                    frame_ch.byte_one <= job.payload.byte_one;
                    frame_ch.byte_two <= job.payload.byte_two;
                    frame_ch.byte_three <= job.payload.byte_three;
                    offer = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            frame_ch.valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_values
        values_t want;
        if (!rst_n)
        begin
            values_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (values_ch.valid && values_ch.ready)
            begin
                if (expected_values.size() == 0)
                    flag_error("values transfer with no frame outstanding");
                else
                begin
                    want = expected_values.pop_front();
                    if (values_ch.engine_rpm !== want.engine_rpm)
                        flag_error($sformatf("engine_rpm %0d, expected %0d",
                                             values_ch.engine_rpm, want.engine_rpm));
                    if (values_ch.road_speed !== want.road_speed)
                        flag_error($sformatf("road_speed %0d, expected %0d",
                                             values_ch.road_speed, want.road_speed));
                    if (values_ch.fuel_percent !== want.fuel_percent)
                        flag_error($sformatf("fuel_percent %0d, expected %0d",
                                             values_ch.fuel_percent, want.fuel_percent));
                    if (values_ch.coolant_celsius !== want.coolant_celsius)
                        flag_error($sformatf("coolant_celsius %0d, expected %0d",
                                             values_ch.coolant_celsius, want.coolant_celsius));
                    if (values_ch.outside_celsius !== want.outside_celsius)
                        flag_error($sformatf("outside_celsius %0d, expected %0d",
                                             values_ch.outside_celsius, want.outside_celsius));
                    if (values_ch.gear_mode !== want.gear_mode)
                        flag_error($sformatf("gear_mode %0d, expected %0d",
                                             values_ch.gear_mode, want.gear_mode));
                    if (values_ch.gear_number !== want.gear_number)
                        flag_error($sformatf("gear_number %0d, expected %0d",
                                             values_ch.gear_number, want.gear_number));
                    if (values_ch.steering_degrees !== want.steering_degrees)
                        flag_error($sformatf("steering_degrees %0d, expected %0d",
                                             values_ch.steering_degrees,
                                             want.steering_degrees));
                end
                if ($urandom_range(0, 31) == 0)
                    sink_calm = !sink_calm;
                stall_left = sink_calm ? 0 : $urandom_range(0, 10);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                values_ch.ready <= 1'b0;
            end
            else
                values_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        add_frame(OP_UNUSED, random_byte(), random_byte(), random_byte(), random_byte(), 1'b0);
        add_frame(OP_RPM, random_byte(), random_byte(), 8'h00, 8'h00, 1'b0);
        add_frame(OP_RPM, random_byte(), random_byte(), 8'hFF, 8'hFF, 1'b0);
        add_frame(OP_SPEED, random_byte(), 8'hFF, 8'hFF, random_byte(), 1'b0);
        add_frame(OP_SPEED, random_byte(), 8'h30, 8'h0E, random_byte(), 1'b0);
        add_frame(OP_SPEED, random_byte(), 8'h40, 8'h0E, random_byte(), 1'b0);
        add_frame(OP_FUEL, random_byte(), random_byte(), 8'h00, random_byte(), 1'b0);
        add_frame(OP_FUEL, random_byte(), random_byte(), 8'h03, random_byte(), 1'b0);
        add_frame(OP_FUEL, random_byte(), random_byte(), 8'h7F, random_byte(), 1'b0);
        add_frame(OP_FUEL, random_byte(), random_byte(), 8'h80, random_byte(), 1'b0);
        add_frame(OP_FUEL, random_byte(), random_byte(), 8'hFF, random_byte(), 1'b0);
        add_frame(OP_COOLANT, random_byte(), 8'h00, random_byte(), random_byte(), 1'b0);
        add_frame(OP_COOLANT, random_byte(), 8'h40, random_byte(), random_byte(), 1'b0);
        add_frame(OP_COOLANT, random_byte(), 8'hEB, random_byte(), random_byte(), 1'b0);
        add_frame(OP_COOLANT, random_byte(), 8'hFF, random_byte(), random_byte(), 1'b0);
        add_frame(OP_OUTSIDE, random_byte(), random_byte(), random_byte(), 8'h80, 1'b0);
        add_frame(OP_OUTSIDE, random_byte(), random_byte(), random_byte(), 8'h81, 1'b0);
        add_frame(OP_OUTSIDE, random_byte(), random_byte(), random_byte(), 8'hFF, 1'b0);
        add_frame(OP_OUTSIDE, random_byte(), random_byte(), random_byte(), 8'h7F, 1'b0);
        add_frame(OP_GEAR, random_byte(), 8'h00, 8'hFF, random_byte(), 1'b0);
        add_frame(OP_GEAR, random_byte(), 8'hFF, 8'h00, random_byte(), 1'b0);
        add_frame(OP_STEER, 8'hFF, 8'h7F, random_byte(), random_byte(), 1'b0);
        add_frame(OP_STEER, 8'hFF, 8'hFF, random_byte(), random_byte(), 1'b0);
        add_frame(OP_STEER, 8'h00, 8'h80, random_byte(), random_byte(), 1'b0);
        add_frame(OP_STEER, 8'h00, 8'h00, random_byte(), random_byte(), 1'b0);
        for (int n = 0; n < RANDOM_FRAMES; n++)
            add_frame(OPCODE_W'($urandom_range(OP_RPM, OP_UNUSED)), random_byte(),
                      random_byte(), random_byte(), random_byte(),
                      n == 0 || n == RANDOM_FRAMES / 2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_frames.size() != 0 || frame_ch.valid)
            @(posedge clk);
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_values.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
